// ===== design/gbn_pkg.sv =====
// shared constants, types and codes of the go-back-n sender
package gbn_pkg;

  // window depth and stored payload width
  localparam int WINDOW       = 8;
  localparam int PAYLOAD_BITS = 32;

  // command queue depth between front and back
  localparam int QUEUE_DEPTH  = 2;

  // derived widths
  localparam int IDX_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int CNT_W = $clog2(WINDOW + 1);

  // field widths
  localparam int MODE_W  = 2;
  localparam int SEQ_W   = 32;
  localparam int DATA_W  = 32;
  localparam int KIND_W  = 3;
  localparam int CFG_W   = 16;
  localparam int BASE_W  = 16;
  localparam int LIMIT_W = 4;

  typedef logic [IDX_W-1:0]        idx_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [CNT_W:0]          idx_sum_t;
  typedef logic [PAYLOAD_BITS-1:0] word_t;
  typedef logic [SEQ_W-1:0]        seq_t;
  typedef logic [KIND_W-1:0]       kind_t;
  typedef logic [BASE_W-1:0]       base_t;
  typedef logic [LIMIT_W-1:0]      limit_t;

  // input modes
  localparam logic [MODE_W-1:0] MODE_SEND    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_ACK     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TIMEOUT = 2'd2;
  localparam logic [MODE_W-1:0] MODE_NOP     = 2'd3;

  // result kinds
  localparam kind_t KIND_SENT     = 3'd0;
  localparam kind_t KIND_REFUSED  = 3'd1;
  localparam kind_t KIND_RELEASED = 3'd2;
  localparam kind_t KIND_REJECTED = 3'd3;
  localparam kind_t KIND_RESENT   = 3'd4;

  // configuration register indexes
  localparam logic CFG_BASE_SEQ     = 1'b0;
  localparam logic CFG_WINDOW_LIMIT = 1'b1;

  localparam base_t  BASE_SEQ_RST     = '0;
  localparam limit_t WINDOW_LIMIT_RST = 4'd4;

  // classified command between front and back
  typedef enum logic [1:0] {
    OP_SEND,
    OP_ACK,
    OP_REJECT,
    OP_TIMEOUT
  } op_t;

  typedef struct packed {
    op_t   op;
    word_t payload;
    seq_t  ack_seq;
  } cmd_t;

  // head of the command queue as seen by the back
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } q_head_t;

endpackage

// ===== design/gbn_if.sv =====
// input and result channel interfaces of the go-back-n sender
interface gbn_in_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::MODE_W-1:0]       mode;
  logic [31:0]                      payload;
  logic [gbn_pkg::SEQ_W-1:0]        ack_seq;
  logic                             ack_checksum_ok;

  modport source (output valid, output mode, output payload, output ack_seq,
                  output ack_checksum_ok, input ready);
  modport sink   (input valid, input mode, input payload, input ack_seq,
                  input ack_checksum_ok, output ready);
endinterface

interface gbn_out_if;
  logic                             valid;
  logic                             ready;
  logic [gbn_pkg::KIND_W-1:0]       kind;
  logic [gbn_pkg::SEQ_W-1:0]        seq;
  logic [gbn_pkg::DATA_W-1:0]       data;
  logic                             timer_start;
  logic                             timer_stop;
  logic                             last;

  modport source (output valid, output kind, output seq, output data,
                  output timer_start, output timer_stop, output last,
                  input ready);
  modport sink   (input valid, input kind, input seq, input data,
                  input timer_start, input timer_stop, input last,
                  output ready);
endinterface

// ===== design/go_back_n_sender.sv =====
// top level of the go-back-n sender window
// Go-Back-N sender: a send, a refused send and a rejected ack each give one
// result; an accepted ack is checked first and then gives one result per
// released packet, and a timeout gives one result per held packet (up to 8)
// or none on an empty window. The rate is set by the single result register
// of the back end, which loads one result per cycle unless it is stalled;
// a two-deep command queue lets inputs be taken while results are still
// being delivered. Mode three is dropped on input and gives no result.
// Configuration is taken on any cycle with cfg_we high and must be written
// only while the block is idle.
module go_back_n_sender (
  input  logic                      clk,
  input  logic                      rst_n,
  gbn_in_if.sink                    in_ch,
  gbn_out_if.source                 out_ch,
  input  logic                      cfg_we,
  input  logic                      cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0] cfg_data
);

  gbn_pkg::q_head_t head;
  logic             pop;

  // input classification and command queue
  gbn_front u_front (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .head  (head),
    .pop   (pop)
  );

  // window execution and results
  gbn_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_ch    (out_ch)
  );

endmodule

// ===== design/gbn_front.sv =====
// front end: takes input transfers, classifies them and queues commands
module gbn_front (
  input  logic              clk,
  input  logic              rst_n,
  gbn_in_if.sink            in_ch,
  output gbn_pkg::q_head_t  head,
  input  logic              pop
);

  gbn_pkg::cmd_t q_r [gbn_pkg::QUEUE_DEPTH];
  logic          head_r, head_nxt;
  logic          tail_r, tail_nxt;
  logic [1:0]    count_r, count_nxt;
  gbn_pkg::cmd_t cmd_in;
  logic          push;
  logic          do_pop;

  // room for one more command
  assign in_ch.ready = (count_r != 2'(gbn_pkg::QUEUE_DEPTH));

  // classify the incoming item
  always_comb begin
    cmd_in.payload = gbn_pkg::word_t'(in_ch.payload);
    cmd_in.ack_seq = in_ch.ack_seq;
    cmd_in.op      = gbn_pkg::OP_SEND;
    push           = in_ch.valid && in_ch.ready;
    unique case (in_ch.mode)
      gbn_pkg::MODE_SEND:    cmd_in.op = gbn_pkg::OP_SEND;
      gbn_pkg::MODE_ACK:     cmd_in.op = in_ch.ack_checksum_ok ? gbn_pkg::OP_ACK
                                                              : gbn_pkg::OP_REJECT;
      gbn_pkg::MODE_TIMEOUT: cmd_in.op = gbn_pkg::OP_TIMEOUT;
      gbn_pkg::MODE_NOP:     push = 1'b0;
      default:               push = 1'b0;
    endcase
  end

  assign head.valid = (count_r != 2'd0);
  assign head.cmd   = q_r[head_r];
  assign do_pop     = pop && head.valid;

  // queue pointers
  always_comb begin
    head_nxt  = do_pop ? ~head_r : head_r;
    tail_nxt  = push ? ~tail_r : tail_r;
    count_nxt = count_r + 2'(push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      head_r  <= head_nxt;
      tail_r  <= tail_nxt;
      count_r <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[tail_r] <= cmd_in;
    end
  end

endmodule

// ===== design/gbn_back.sv =====
// back end: window state, packet store and result sequencing
module gbn_back (
  input  logic                    clk,
  input  logic                    rst_n,
  input  gbn_pkg::q_head_t        head,
  output logic                    pop,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [gbn_pkg::CFG_W-1:0] cfg_data,
  gbn_out_if.source               out_ch
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_ACK    = 3'b010,
    ST_RESEND = 3'b100
  } state_t;

  state_t               state_r, state_nxt;
  gbn_pkg::word_t       store_r [gbn_pkg::WINDOW];
  gbn_pkg::idx_t        oldest_r, oldest_nxt;
  gbn_pkg::cnt_t        held_r, held_nxt;
  gbn_pkg::seq_t        sent_r, sent_nxt;
  gbn_pkg::seq_t        ack_r, ack_nxt;
  gbn_pkg::seq_t        cur_seq_r, cur_seq_nxt;
  gbn_pkg::idx_t        idx_r, idx_nxt;
  gbn_pkg::base_t       base_r;
  gbn_pkg::limit_t      limit_r;

  logic                 out_valid_r, out_valid_nxt;
  gbn_pkg::kind_t       out_kind_r, out_kind_nxt;
  gbn_pkg::seq_t        out_seq_r, out_seq_nxt;
  logic [gbn_pkg::DATA_W-1:0] out_data_r, out_data_nxt;
  logic                 out_ts_r, out_ts_nxt;
  logic                 out_tp_r, out_tp_nxt;
  logic                 out_last_r, out_last_nxt;

  logic                 adv;
  logic                 wr_en;
  gbn_pkg::idx_t        wr_idx;
  gbn_pkg::cnt_t        limit;
  gbn_pkg::seq_t        send_seq;
  gbn_pkg::seq_t        oldest_seq;
  gbn_pkg::seq_t        next_seq;
  gbn_pkg::idx_t        rd_idx;

  // circular index add, first operand below and second up to the window depth
  function automatic gbn_pkg::idx_t add_idx(gbn_pkg::idx_t a, gbn_pkg::cnt_t b);
    gbn_pkg::idx_sum_t s;
    s = gbn_pkg::idx_sum_t'(a) + gbn_pkg::idx_sum_t'(b);
    if (s >= gbn_pkg::idx_sum_t'(gbn_pkg::WINDOW)) begin
      s = s - gbn_pkg::idx_sum_t'(gbn_pkg::WINDOW);
    end
    return gbn_pkg::idx_t'(s);
  endfunction

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r  <= gbn_pkg::BASE_SEQ_RST;
      limit_r <= gbn_pkg::WINDOW_LIMIT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gbn_pkg::CFG_BASE_SEQ:     base_r  <= cfg_data[gbn_pkg::BASE_W-1:0];
        gbn_pkg::CFG_WINDOW_LIMIT: limit_r <= cfg_data[gbn_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // limit clamped to the store depth
  always_comb begin
    if (32'(limit_r) > 32'(gbn_pkg::WINDOW)) begin
      limit = gbn_pkg::cnt_t'(gbn_pkg::WINDOW);
    end else begin
      limit = gbn_pkg::cnt_t'(limit_r);
    end
  end

  // sequence numbers of the next new packet and of the oldest held one
  assign send_seq   = gbn_pkg::seq_t'(base_r) + sent_r;
  assign oldest_seq = send_seq - gbn_pkg::seq_t'(held_r);
  assign next_seq   = cur_seq_r + gbn_pkg::seq_t'(1);
  assign wr_idx     = add_idx(oldest_r, held_r);
  assign rd_idx     = add_idx(oldest_r, gbn_pkg::cnt_t'(idx_r));

  // result register may load when empty or being taken
  assign adv = !out_valid_r || out_ch.ready;

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    held_nxt      = held_r;
    sent_nxt      = sent_r;
    ack_nxt       = ack_r;
    cur_seq_nxt   = cur_seq_r;
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_seq_nxt   = out_seq_r;
    out_data_nxt  = out_data_r;
    out_ts_nxt    = out_ts_r;
    out_tp_nxt    = out_tp_r;
    out_last_nxt  = out_last_r;
    wr_en         = 1'b0;
    pop           = 1'b0;

    if (adv) begin
      unique case (state_r)
        ST_IDLE: begin
          if (head.valid) begin
            pop          = 1'b1;
            out_seq_nxt  = '0;
            out_data_nxt = '0;
            out_ts_nxt   = 1'b0;
            out_tp_nxt   = 1'b0;
            out_last_nxt = 1'b1;
            unique case (head.cmd.op)
              gbn_pkg::OP_SEND: begin
                out_valid_nxt = 1'b1;
                if (held_r >= limit) begin
                  out_kind_nxt = gbn_pkg::KIND_REFUSED;
                end else begin
                  wr_en        = 1'b1;
                  held_nxt     = held_r + gbn_pkg::cnt_t'(1);
                  sent_nxt     = sent_r + gbn_pkg::seq_t'(1);
                  out_kind_nxt = gbn_pkg::KIND_SENT;
                  out_seq_nxt  = send_seq;
                  out_data_nxt = gbn_pkg::DATA_W'(head.cmd.payload);
                  out_ts_nxt   = 1'b1;
                end
              end
              gbn_pkg::OP_ACK: begin
                if (held_r != '0 && oldest_seq <= head.cmd.ack_seq) begin
                  ack_nxt     = head.cmd.ack_seq;
                  cur_seq_nxt = oldest_seq;
                  state_nxt   = ST_ACK;
                end else begin
                  out_valid_nxt = 1'b1;
                  out_kind_nxt  = gbn_pkg::KIND_REJECTED;
                end
              end
              gbn_pkg::OP_REJECT: begin
                out_valid_nxt = 1'b1;
                out_kind_nxt  = gbn_pkg::KIND_REJECTED;
              end
              gbn_pkg::OP_TIMEOUT: begin
                // empty window gives no results
                if (held_r != '0) begin
                  cur_seq_nxt = oldest_seq;
                  idx_nxt     = '0;
                  state_nxt   = ST_RESEND;
                end
              end
              default: ;
            endcase
          end
        end
        ST_ACK: begin
          // release the oldest packet, one a cycle while the result register can load
          out_valid_nxt = 1'b1;
          out_kind_nxt  = gbn_pkg::KIND_RELEASED;
          out_seq_nxt   = cur_seq_r;
          out_data_nxt  = '0;
          out_ts_nxt    = 1'b0;
          out_tp_nxt    = 1'b1;
          out_last_nxt  = (held_r == gbn_pkg::cnt_t'(1)) || (next_seq > ack_r);
          oldest_nxt    = add_idx(oldest_r, gbn_pkg::cnt_t'(1));
          held_nxt      = held_r - gbn_pkg::cnt_t'(1);
          cur_seq_nxt   = next_seq;
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
        ST_RESEND: begin
          // resend held packets oldest first
          out_valid_nxt = 1'b1;
          out_kind_nxt  = gbn_pkg::KIND_RESENT;
          out_seq_nxt   = cur_seq_r;
          out_data_nxt  = gbn_pkg::DATA_W'(store_r[rd_idx]);
          out_ts_nxt    = 1'b1;
          out_tp_nxt    = 1'b0;
          out_last_nxt  = (gbn_pkg::cnt_t'(idx_r) + gbn_pkg::cnt_t'(1)) == held_r;
          cur_seq_nxt   = next_seq;
          idx_nxt       = idx_r + gbn_pkg::idx_t'(1);
          if (out_last_nxt) begin
            state_nxt = ST_IDLE;
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      oldest_r    <= '0;
      held_r      <= '0;
      sent_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      held_r      <= held_nxt;
      sent_r      <= sent_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // working and result payload registers
  always_ff @(posedge clk) begin
    ack_r      <= ack_nxt;
    cur_seq_r  <= cur_seq_nxt;
    idx_r      <= idx_nxt;
    out_kind_r <= out_kind_nxt;
    out_seq_r  <= out_seq_nxt;
    out_data_r <= out_data_nxt;
    out_ts_r   <= out_ts_nxt;
    out_tp_r   <= out_tp_nxt;
    out_last_r <= out_last_nxt;
  end

  // packet store
  always_ff @(posedge clk) begin
    if (wr_en) begin
      store_r[wr_idx] <= head.cmd.payload;
    end
  end

  // result channel
  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.seq         = out_seq_r;
  assign out_ch.data        = out_data_r;
  assign out_ch.timer_start = out_ts_r;
  assign out_ch.timer_stop  = out_tp_r;
  assign out_ch.last        = out_last_r;

endmodule

// ===== design/gbn_checker.sv =====
// port-level assertions for the go-back-n sender and their bind
module gbn_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [gbn_pkg::KIND_W-1:0]  out_kind,
  input logic [gbn_pkg::SEQ_W-1:0]   out_seq,
  input logic                        out_timer_start,
  input logic                        out_timer_stop,
  input logic                        out_last
);

  // a waiting result stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped before transfer");

  // only defined kinds appear
  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_kind <= gbn_pkg::KIND_RESENT)
    else $error("undefined result kind");

  // timer start goes with sent and resent packets
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_timer_start ==
      (out_kind == gbn_pkg::KIND_SENT || out_kind == gbn_pkg::KIND_RESENT))
    else $error("timer start mismatch");

  // timer stop goes with released packets
  a_stop: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_timer_stop == (out_kind == gbn_pkg::KIND_RELEASED))
    else $error("timer stop mismatch");

  // refusals and rejections are single results with no number
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_kind == gbn_pkg::KIND_REFUSED ||
                  out_kind == gbn_pkg::KIND_REJECTED)
      |-> out_last && out_seq == '0)
    else $error("refused or rejected result malformed");

endmodule

bind go_back_n_sender gbn_checker u_gbn_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_ch.valid),
  .out_ready       (out_ch.ready),
  .out_kind        (out_ch.kind),
  .out_seq         (out_ch.seq),
  .out_timer_start (out_ch.timer_start),
  .out_timer_stop  (out_ch.timer_stop),
  .out_last        (out_ch.last)
);
